// ===== sv/multilevel_priority_fifo_unit_assert.svh =====
// Assertion macros shared by the checker.
`ifndef MULTILEVEL_PRIORITY_FIFO_UNIT_ASSERT_SVH
`define MULTILEVEL_PRIORITY_FIFO_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define MLPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define MLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mlpq_pkg.sv =====
`timescale 1ns / 1ps
package mlpq_pkg;

    // Request kinds
    localparam logic [1:0] KIND_ENQ   = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_EXACT = 2'd2;
    localparam logic [1:0] KIND_LIMIT = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Level search group width
    localparam int GRP = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  level;
        logic [63:0] payload;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] out_payload;
        logic [7:0]  out_level;
    } rsp_t;

    // Classified request as held in the command queue
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  level;
        logic [7:0]  lim;
        logic        lv_ok;
        logic [63:0] payload;
    } cmd_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ENQ  = 7'b0000010,
        S_GRP  = 7'b0000100,
        S_OFF  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_LNK  = 7'b0100000,
        S_POP  = 7'b1000000
    } back_state_t;

endpackage

// ===== sv/mlpq_ram.sv =====
`timescale 1ns / 1ps
module mlpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/mlpq_front.sv =====
`timescale 1ns / 1ps
module mlpq_front #(
    parameter int LEVELS = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mlpq_pkg::req_t req,
    output logic           q_valid,
    output mlpq_pkg::cmd_t q_cmd,
    input  logic           q_pop
);
    mlpq_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    mlpq_pkg::cmd_t cls;
    logic           push;

    // Classify: range check on level, saturate the limit
    always_comb
    begin
        cls.kind    = req.kind;
        cls.level   = req.level;
        cls.payload = req.payload;
        cls.lv_ok   = (9'(req.level) < 9'(LEVELS));
        if (req.kind == mlpq_pkg::KIND_FIRST || !cls.lv_ok)
        begin
            cls.lim = 8'(LEVELS - 1);
        end
        else
        begin
            cls.lim = req.level;
        end
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_cmd     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

// ===== sv/mlpq_back.sv =====
`timescale 1ns / 1ps
module mlpq_back #(
    parameter int LEVELS       = 256,
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mlpq_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mlpq_pkg::rsp_t rsp
);
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int NGRP  = (LEVELS + mlpq_pkg::GRP - 1) / mlpq_pkg::GRP;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int VEC_W = NGRP * mlpq_pkg::GRP;

    mlpq_pkg::back_state_t state_reg, state_next;
    mlpq_pkg::cmd_t        cmd_reg, cmd_next;
    logic [LEVELS-1:0]     ne_reg, ne_next;
    logic [VEC_W-1:0]      vec_reg, vec_next;
    logic [GW-1:0]         grp_reg, grp_next;
    logic [LVL_W-1:0]      lv_reg, lv_next;
    logic                  hit_reg, hit_next;
    logic                  stk_reg, stk_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [SW-1:0]         hd_reg, hd_next;
    logic                  last_reg, last_next;
    logic [CW-1:0]         fresh_reg, fresh_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    mlpq_pkg::rsp_t        rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic                    data_we, link_we, head_we, tail_we, free_we;
    logic [SW-1:0]           data_waddr, data_raddr, link_waddr, link_raddr;
    logic [SW-1:0]           free_waddr, free_raddr;
    logic [LVL_W-1:0]        head_waddr, head_raddr, tail_waddr, tail_raddr;
    logic [PAYLOAD_BITS-1:0] data_wdata, data_rdata;
    logic [SW-1:0]           link_wdata, link_rdata, head_wdata, head_rdata;
    logic [SW-1:0]           tail_wdata, tail_rdata, free_wdata, free_rdata;

    logic [LVL_W-1:0]        q_lv;
    logic                    res_free;
    logic [VEC_W-1:0]        ne_pad;
    logic                    g_found;
    logic [GW-1:0]           g_sel;
    logic [mlpq_pkg::GRP-1:0] off_bits;
    logic [3:0]              off_sel;
    logic [SW-1:0]           enq_slot;

    assign q_lv     = q_cmd.level[LVL_W-1:0];
    assign res_free = !rsp_valid_reg || rsp_ready;
    assign ne_pad   = VEC_W'(ne_reg);
    assign enq_slot = stk_reg ? free_rdata : slot_reg;

    // Lowest nonempty group
    always_comb
    begin
        g_found = 1'b0;
        g_sel   = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (|vec_reg[g*mlpq_pkg::GRP +: mlpq_pkg::GRP])
            begin
                g_found = 1'b1;
                g_sel   = GW'(g);
            end
        end
    end

    // Lowest set level within the chosen group
    assign off_bits = vec_reg[grp_reg*mlpq_pkg::GRP +: mlpq_pkg::GRP];
    always_comb
    begin
        off_sel = '0;
        for (int i = mlpq_pkg::GRP - 1; i >= 0; i--)
        begin
            if (off_bits[i])
            begin
                off_sel = 4'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ne_next        = ne_reg;
        vec_next       = vec_reg;
        grp_next       = grp_reg;
        lv_next        = lv_reg;
        hit_next       = hit_reg;
        stk_next       = stk_reg;
        slot_next      = slot_reg;
        hd_next        = hd_reg;
        last_next      = last_reg;
        fresh_next     = fresh_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        q_pop          = 1'b0;

        data_we    = 1'b0;
        data_waddr = enq_slot;
        data_wdata = cmd_reg.payload[PAYLOAD_BITS-1:0];
        data_raddr = head_rdata;
        link_we    = 1'b0;
        link_waddr = tail_rdata;
        link_wdata = enq_slot;
        link_raddr = head_rdata;
        head_we    = 1'b0;
        head_waddr = lv_reg;
        head_wdata = link_rdata;
        head_raddr = lv_reg;
        tail_we    = 1'b0;
        tail_waddr = lv_reg;
        tail_wdata = enq_slot;
        tail_raddr = lv_reg;
        free_we    = 1'b0;
        free_waddr = cnt_reg[SW-1:0];
        free_wdata = hd_reg;
        free_raddr = SW'(cnt_reg - CW'(1));

        case (state_reg)
            mlpq_pkg::S_IDLE:
            begin
                if (q_valid && res_free)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    lv_next    = q_lv;
                    tail_raddr = q_lv;
                    rsp_next   = '{status: mlpq_pkg::ST_EMPTY, out_payload: 64'd0,
                                   out_level: 8'd0};
                    case (q_cmd.kind)
                        mlpq_pkg::KIND_ENQ:
                        begin
                            hit_next = ne_reg[q_lv];
                            if (!q_cmd.lv_ok)
                            begin
                                rsp_next.status = mlpq_pkg::ST_FULL;
                                rsp_valid_next  = 1'b1;
                            end
                            else if (cnt_reg != '0)
                            begin
                                stk_next   = 1'b1;
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = mlpq_pkg::S_ENQ;
                            end
                            else if (fresh_reg != CW'(CAPACITY))
                            begin
                                stk_next   = 1'b0;
                                slot_next  = fresh_reg[SW-1:0];
                                fresh_next = fresh_reg + CW'(1);
                                state_next = mlpq_pkg::S_ENQ;
                            end
                            else
                            begin
                                rsp_next.status = mlpq_pkg::ST_FULL;
                                rsp_valid_next  = 1'b1;
                            end
                        end
                        mlpq_pkg::KIND_EXACT:
                        begin
                            if (q_cmd.lv_ok && ne_reg[q_lv])
                            begin
                                state_next = mlpq_pkg::S_RD;
                            end
                            else
                            begin
                                rsp_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            for (int i = 0; i < VEC_W; i++)
                            begin
                                vec_next[i] = ne_pad[i] && (10'(i) <= 10'(q_cmd.lim));
                            end
                            state_next = mlpq_pkg::S_GRP;
                        end
                    endcase
                end
            end
            mlpq_pkg::S_ENQ:
            begin
                data_we    = 1'b1;
                head_waddr = lv_reg;
                head_wdata = enq_slot;
                link_we    = hit_reg;
                head_we    = !hit_reg;
                tail_we    = 1'b1;
                ne_next[lv_reg] = 1'b1;
                rsp_next.status = mlpq_pkg::ST_ENQUEUED;
                rsp_valid_next  = 1'b1;
                state_next      = mlpq_pkg::S_IDLE;
            end
            mlpq_pkg::S_GRP:
            begin
                grp_next = g_sel;
                if (g_found)
                begin
                    state_next = mlpq_pkg::S_OFF;
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = mlpq_pkg::S_IDLE;
                end
            end
            mlpq_pkg::S_OFF:
            begin
                lv_next    = LVL_W'({grp_reg, off_sel});
                state_next = mlpq_pkg::S_RD;
            end
            mlpq_pkg::S_RD:
            begin
                state_next = mlpq_pkg::S_LNK;
            end
            mlpq_pkg::S_LNK:
            begin
                hd_next    = head_rdata;
                last_next  = (head_rdata == tail_rdata);
                state_next = mlpq_pkg::S_POP;
            end
            mlpq_pkg::S_POP:
            begin
                free_we  = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (last_reg)
                begin
                    ne_next[lv_reg] = 1'b0;
                end
                else
                begin
                    head_we = 1'b1;
                end
                rsp_next.status      = mlpq_pkg::ST_DEQUEUED;
                rsp_next.out_payload = 64'(data_rdata);
                rsp_next.out_level   = 8'(lv_reg);
                rsp_valid_next       = 1'b1;
                state_next           = mlpq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mlpq_pkg::S_IDLE;
            end
        endcase
    end

    mlpq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(CAPACITY)) u_data (
        .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
        .raddr(data_raddr), .rdata(data_rdata)
    );
    mlpq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );
    mlpq_ram #(.WIDTH(SW), .DEPTH(LEVELS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    mlpq_ram #(.WIDTH(SW), .DEPTH(LEVELS)) u_tail (
        .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
        .raddr(tail_raddr), .rdata(tail_rdata)
    );
    mlpq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
        .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .raddr(free_raddr), .rdata(free_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        vec_reg  <= vec_next;
        grp_reg  <= grp_next;
        lv_reg   <= lv_next;
        hit_reg  <= hit_next;
        stk_reg  <= stk_next;
        slot_reg <= slot_next;
        hd_reg   <= hd_next;
        last_reg <= last_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlpq_pkg::S_IDLE;
            ne_reg        <= '0;
            fresh_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            fresh_reg     <= fresh_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end
endmodule

// ===== sv/multilevel_priority_fifo_unit.sv =====
`timescale 1ns / 1ps
// Priority queue with one FIFO per level (level 0 most urgent) over a shared
// pool of CAPACITY entries. Each request is an enqueue, a dequeue of the most
// urgent entry, a dequeue of one exact level, or a dequeue of the most urgent
// entry at or below a limit; each gives exactly one response carrying a
// status, and for a dequeue the payload and its level. A two-deep command
// queue takes requests while the engine works and a response register holds
// a finished response, so each side may stall on its own. The engine handles
// one request at a time; its steps follow the walk through the synchronous
// RAMs (head and tail pointers, then link and payload, then pointer update)
// and, for searched dequeues, the two-step level search over groups of 16
// level flags. Free entries come from a free-slot stack when it holds any
// and otherwise from a fresh counter, so no clearing pass follows reset.
module multilevel_priority_fifo_unit #(
    parameter int LEVELS       = 256,
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mlpq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mlpq_pkg::rsp_t rsp
);
    logic           q_valid;
    logic           q_pop;
    mlpq_pkg::cmd_t q_cmd;

    // Front: accept and classify each request, queue it
    mlpq_front #(.LEVELS(LEVELS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    // Back: carry out each request against the pool and emit its response
    mlpq_back #(
        .LEVELS(LEVELS), .CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );
endmodule

// ===== sv/mlpq_checker.sv =====
`timescale 1ns / 1ps
`include "multilevel_priority_fifo_unit_assert.svh"
module mlpq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input mlpq_pkg::rsp_t rsp
);
    logic [2:0] open_reg, open_next;
    logic       req_acc, rsp_acc;
    logic       rsp_unused, rsp_zero;

    assign req_acc    = req_valid && req_ready;
    assign rsp_acc    = rsp_valid && rsp_ready;
    assign open_next  = open_reg + 3'(req_acc) - 3'(rsp_acc);
    assign rsp_unused = rsp_valid && (rsp.status != mlpq_pkg::ST_DEQUEUED);
    assign rsp_zero   = (rsp.out_payload == 64'd0) && (rsp.out_level == 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 3'd0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    `MLPQ_ASSERT_NOW(a_no_orphan_rsp, rsp_valid, open_reg != 3'd0, "response without request")
    `MLPQ_ASSERT_NOW(a_open_bound, 1'b1, open_reg <= 3'd4, "too many open requests")
    `MLPQ_ASSERT_NOW(a_zero_fields, rsp_unused, rsp_zero, "unused fields not zero")
    `MLPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")
endmodule

bind multilevel_priority_fifo_unit mlpq_checker u_mlpq_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req_valid), .req_ready(req_ready),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
